// ----- rtl/ipv4_address_pool_allocator_macros.svh -----
// Assertion macros shared by the address pool allocator RTL.
// Included by modules that carry concurrent checks; relies on clk_i and rst_ni.
`ifndef IPV4_ADDRESS_POOL_ALLOCATOR_MACROS_SVH
`define IPV4_ADDRESS_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IPAP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IPAP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ipv4ap_pkg.sv -----
// Shared types and constants of the IPv4 address pool allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ipv4ap_pkg;

  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned BIT_IDX_W      = 5;
  localparam int unsigned DEF_POOL_SLOTS = 256;

  localparam logic [31:0] NET_RESET  = 32'h0000_0000;
  localparam logic [31:0] MASK_RESET = 32'hFFFF_FF00;

  // Register index, taken from paddr[2].
  localparam logic REG_NETWORK = 1'b0;
  localparam logic REG_MASK    = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic we;
    logic re;
  } map_req_t;

endpackage

`default_nettype wire

// ----- rtl/ipv4ap_cfg.sv -----
// Configuration registers (network address, netmask) behind an APB-style port.
// Derives the first host address and the clamped slot count. Uses ipv4ap_pkg.
`default_nettype none

module ipv4ap_cfg
  import ipv4ap_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  localparam int unsigned MAP_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned CW        = $clog2(MAP_WORDS * WORD_BITS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output logic      [31:0]   base_o,
  output logic      [CW-1:0] slot_count_o
);

  logic [31:0] net_q;
  logic [31:0] mask_q;
  logic [31:0] host_bits;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q  <= NET_RESET;
      mask_q <= MASK_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_NETWORK: net_q  <= pwdata;
        REG_MASK:    mask_q <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NETWORK: prdata = net_q;
      REG_MASK:    prdata = mask_q;
      default:     prdata = '0;
    endcase
  end

  assign host_bits = ~mask_q;
  assign base_o    = (net_q & mask_q) + 32'd1;

  // A /31 or /32 has no usable host; larger subnets are clamped to POOL_SLOTS.
  always_comb begin
    if (host_bits < 32'd2) begin
      slot_count_o = '0;
    end else if (host_bits > 32'(POOL_SLOTS) + 32'd1) begin
      slot_count_o = CW'(POOL_SLOTS);
    end else begin
      slot_count_o = CW'(host_bits - 32'd1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipv4ap_map_mem.sv -----
// In-use bitmap storage: one synchronous word-wide RAM, one write and one read port.
// Read data is registered. Uses ipv4ap_pkg.
`default_nettype none

module ipv4ap_map_mem
  import ipv4ap_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic                 clk_i,
  input  wire map_req_t             req_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WORD_BITS-1:0] wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/ipv4ap_ctrl.sv -----
// Sequencer of the allocator: clearing pass, word-wise first-fit scan, release
// read-modify-write and the output register. Uses ipv4ap_pkg and the macro header.
`default_nettype none
`include "ipv4_address_pool_allocator_macros.svh"

module ipv4ap_ctrl
  import ipv4ap_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS,
  localparam int unsigned MAP_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int unsigned CW        = $clog2(MAP_WORDS * WORD_BITS + 1),
  localparam int unsigned SW        = AW + BIT_IDX_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 in_mode_i,
  input  wire logic [31:0]          in_addr_i,
  input  wire logic [31:0]          base_i,
  input  wire logic [CW-1:0]        slot_count_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output status_e                   out_status_o,
  output logic      [31:0]          out_granted_o,
  output map_req_t                  mem_req_o,
  output logic      [AW-1:0]        mem_waddr_o,
  output logic      [WORD_BITS-1:0] mem_wdata_o,
  output logic      [AW-1:0]        mem_raddr_o,
  input  wire logic [WORD_BITS-1:0] mem_rdata_i
);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_SCAN    = 6'b000100,
    S_REL_CHK = 6'b001000,
    S_REL_WR  = 6'b010000,
    S_DONE    = 6'b100000
  } ctrl_state_e;

  function automatic logic [BIT_IDX_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) idx = BIT_IDX_W'(k);
    end
    return idx;
  endfunction

  ctrl_state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   word_q, word_d;
  logic [SW-1:0]   slot_q, slot_d;
  status_e         status_q, status_d;
  logic            mode_q;
  logic [31:0]     addr_q;
  logic [31:0]     base_q;
  logic [CW-1:0]   cnt_q;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  logic [31:0]     out_granted_q, out_granted_d;

  logic                  accept;
  logic                  out_free;
  logic [CW-6:0]         word_ext;
  logic [CW-6:0]         word_hi;
  logic [CW-1:0]         next_start;
  logic                  last_word;
  logic [WORD_BITS-1:0]  valid_mask;
  logic [WORD_BITS-1:0]  free_vec;
  logic                  hit;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic [31:0]           rel_off;
  logic                  rel_in_range;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Slots at or above the count are treated as taken, so they never win the scan.
  assign word_ext   = (CW - 5)'(word_q);
  assign word_hi    = cnt_q[CW-1:BIT_IDX_W];
  assign next_start = {word_ext + (CW - 5)'(1), BIT_IDX_W'(0)};
  assign last_word  = (next_start >= cnt_q);

  always_comb begin
    if (word_ext < word_hi) begin
      valid_mask = '1;
    end else if (word_ext == word_hi) begin
      valid_mask = ~({WORD_BITS{1'b1}} << cnt_q[BIT_IDX_W-1:0]);
    end else begin
      valid_mask = '0;
    end
  end

  assign free_vec     = ~mem_rdata_i & valid_mask;
  assign hit          = |free_vec;
  assign hit_bit      = first_set(free_vec);
  assign rel_off      = addr_q - base_q;
  assign rel_in_range = (rel_off < 32'(cnt_q));

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    word_d        = word_q;
    slot_d        = slot_q;
    status_d      = status_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_status_d  = out_status_q;
    out_granted_d = out_granted_q;
    mem_req_o     = '0;
    mem_waddr_o   = '0;
    mem_wdata_o   = '0;
    mem_raddr_o   = '0;

    case (state_q)
      S_CLEAR: begin
        mem_req_o.we = 1'b1;
        mem_waddr_o  = clr_q;
        clr_d        = clr_q + AW'(1);
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          word_d = '0;
          if (in_mode_i) begin
            state_d = S_REL_CHK;
          end else begin
            mem_req_o.re = 1'b1;
            state_d      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_req_o.we = 1'b1;
          mem_waddr_o  = word_q;
          mem_wdata_o  = mem_rdata_i | (WORD_BITS'(1) << hit_bit);
          slot_d       = {word_q, hit_bit};
          status_d     = STS_OK;
          state_d      = S_DONE;
        end else if (last_word) begin
          status_d = STS_EMPTY;
          state_d  = S_DONE;
        end else begin
          word_d       = word_q + AW'(1);
          mem_req_o.re = 1'b1;
          mem_raddr_o  = word_q + AW'(1);
        end
      end
      S_REL_CHK: begin
        if (rel_in_range) begin
          mem_req_o.re = 1'b1;
          mem_raddr_o  = rel_off[SW-1:BIT_IDX_W];
          slot_d       = rel_off[SW-1:0];
          state_d      = S_REL_WR;
        end else begin
          status_d = STS_RANGE;
          state_d  = S_DONE;
        end
      end
      S_REL_WR: begin
        mem_req_o.we = 1'b1;
        mem_waddr_o  = slot_q[SW-1:BIT_IDX_W];
        mem_wdata_o  = mem_rdata_i & ~(WORD_BITS'(1) << slot_q[BIT_IDX_W-1:0]);
        status_d     = STS_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          if (status_q == STS_OK && !mode_q) begin
            out_granted_d = base_q + 32'(slot_q);
          end else begin
            out_granted_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q        <= word_d;
    slot_q        <= slot_d;
    status_q      <= status_d;
    out_status_q  <= out_status_d;
    out_granted_q <= out_granted_d;
    if (accept) begin
      mode_q <= in_mode_i;
      addr_q <= in_addr_i;
      base_q <= base_i;
      cnt_q  <= slot_count_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_granted_o = out_granted_q;

  `IPAP_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !in_ready_o, "item taken during clear")
  `IPAP_ASSERT_NXT(a_one_item_at_a_time, accept, !in_ready_o, "second item taken while busy")
  `IPAP_ASSERT_IMP(a_no_rw_same_word, mem_req_o.we && mem_req_o.re, mem_waddr_o != mem_raddr_o, "read and write hit one word")
  `IPAP_ASSERT_IMP(a_release_not_empty, state_q == S_DONE && mode_q, status_q != STS_EMPTY, "release reported pool empty")

endmodule

`default_nettype wire

// ----- rtl/ipv4_address_pool_allocator.sv -----
// Usage:
// Allocates and frees IPv4 host addresses of one subnet. Requests enter on the
// s_axis channel: tuser carries the mode (0 allocate, 1 release) and tdata the
// address to release. Each request yields exactly one item on m_axis: tuser is
// the status (0 ok, 1 pool empty, 2 release out of range) and tdata the granted
// address (zero unless an allocation succeeded).
// The subnet is set through the APB-style port: network address at 0x0, netmask
// at 0x4. Write it only while no request is in flight.
// An allocation scans 1 to ceil(POOL_SLOTS/32) 32-bit bitmap words (8 at the default
// size), first fit; the scan reads one word per cycle from the bitmap RAM, whose read
// data is registered. A release in range reads and rewrites its bitmap word; one out
// of range is answered with status 2 and leaves the bitmap as it is.
// One request is worked on at a time; the next can be taken as soon as the
// result has moved to the output register, which may still wait for the receiver.
// After reset the bitmap RAM is cleared one word per cycle, and s_axis_tready stays
// low during that pass. A stalled receiver holds the result in place; one more
// request is still taken and finished, and then s_axis_tready stays low until the
// output is free.
// Depends on ipv4ap_pkg, ipv4ap_cfg, ipv4ap_ctrl and ipv4ap_map_mem.
`default_nettype none

module ipv4_address_pool_allocator
  import ipv4ap_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DEF_POOL_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] release_address
  input  wire logic        s_axis_tuser,   // [0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] granted_address
  output logic      [1:0]  m_axis_tuser,   // [1:0] status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned MAP_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CW        = $clog2(MAP_WORDS * WORD_BITS + 1);

  logic [31:0]          base;
  logic [CW-1:0]        slot_count;
  status_e              out_status;
  map_req_t             mem_req;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  ipv4ap_cfg #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .base_o       (base),
    .slot_count_o (slot_count)
  );

  ipv4ap_ctrl #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_mode_i     (s_axis_tuser),
    .in_addr_i     (s_axis_tdata),
    .base_i        (base),
    .slot_count_i  (slot_count),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (out_status),
    .out_granted_o (m_axis_tdata),
    .mem_req_o     (mem_req),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  ipv4ap_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

// ----- verif/tb_ipv4_address_pool_allocator.sv -----
// Self-checking testbench for the IPv4 address pool allocator: directed rows,
// then random subnet phases, checked against a bitmap first-fit predictor or,
// for typed rows, their own result. Depends on ipv4ap_pkg and ipv4_address_pool_allocator.
`timescale 1ns / 100ps

module tb_ipv4_address_pool_allocator;
  import ipv4ap_pkg::*;

  localparam int unsigned SLOTS       = DEF_POOL_SLOTS;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned CYCLE_LIMIT = 600000;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    status_e     status;
    logic [31:0] grant;
  } lease_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_NET,
    ROW_MASK
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode;
    logic [31:0] value;
    logic        typed;
    lease_t      want;
  } row_t;

  // The typed rows start from the reset subnet 0.0.0.0/24.
  localparam int unsigned PLAN_ROWS = 27;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_REQ,  MODE_ALLOC, 32'hFFFF_FFFF, 1'b1, '{STS_OK,    32'h0000_0001}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b1, '{STS_OK,    32'h0000_0002}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_0001, 1'b1, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_0001, 1'b1, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'hFFFF_FFFF, 1'b1, '{STS_RANGE, 32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_0000, 1'b1, '{STS_RANGE, 32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_00FF, 1'b1, '{STS_RANGE, 32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_00FE, 1'b1, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h5555_AAAA, 1'b0, '{STS_OK,    32'h0000_0000}},
    // A /30 whose two slots are still marked from the /24 above.
    '{ROW_NET,  MODE_ALLOC, 32'hC0A8_0107, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_MASK, MODE_ALLOC, 32'hFFFF_FFFC, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b1, '{STS_EMPTY, 32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'hC0A8_0106, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'hAAAA_5555, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_MASK, MODE_ALLOC, 32'hFFFF_FFFE, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b1, '{STS_EMPTY, 32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'hC0A8_0106, 1'b1, '{STS_RANGE, 32'h0000_0000}},
    '{ROW_MASK, MODE_ALLOC, 32'hFFFF_FFFF, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'hFFFF_FFFF, 1'b1, '{STS_EMPTY, 32'h0000_0000}},
    '{ROW_MASK, MODE_ALLOC, 32'h0000_0000, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'h0000_0100, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_MASK, MODE_ALLOC, 32'hFF00_FF0F, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_NET,  MODE_ALLOC, 32'hFFFF_FFFF, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_FREE,  32'hFFFF_FFFF, 1'b0, '{STS_OK,    32'h0000_0000}},
    '{ROW_REQ,  MODE_ALLOC, 32'h0000_0000, 1'b0, '{STS_OK,    32'h0000_0000}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] release_address
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] granted_address
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ipv4_address_pool_allocator #(
    .POOL_SLOTS(SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predictor state: subnet registers and the in-use bitmap.
  logic [31:0] pool_net;
  logic [31:0] pool_mask;
  bit          lease_map [SLOTS];

  lease_t      pending_leases [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned leases_seen;
  int unsigned cycle_count;
  bit          steady;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h, want %08h (result %0d)", what, got, want,
             leases_seen);
    fail_count++;
  endtask

  function automatic logic [31:0] pool_size();
    logic [31:0] host_bits;
    host_bits = ~pool_mask;
    if (host_bits < 2) return 32'd0;
    return (host_bits - 1 > SLOTS) ? SLOTS : host_bits - 1;
  endfunction

  function automatic logic [31:0] pool_base();
    return (pool_net & pool_mask) + 32'd1;
  endfunction

  function automatic lease_t lease_step(input logic mode, input logic [31:0] addr);
    lease_t      r;
    logic [31:0] span;
    logic [31:0] base;
    logic [31:0] off;
    span     = pool_size();
    base     = pool_base();
    r.status = STS_EMPTY;
    r.grant  = '0;
    if (mode == MODE_ALLOC) begin
      for (int i = 0; i < span; i++) begin
        if (!lease_map[i]) begin
          lease_map[i] = 1'b1;
          r.grant      = base + i;
          r.status     = STS_OK;
          break;
        end
      end
    end else begin
      off = addr - base;
      if (off < span) begin
        lease_map[off] = 1'b0;
        r.status       = STS_OK;
      end else begin
        r.status = STS_RANGE;
      end
    end
    return r;
  endfunction

  task automatic offer(input logic mode, input logic [31:0] addr, input bit typed,
                       input lease_t want);
    lease_t got;
    steady = (items_sent >= 800 && items_sent < 1000);
    if (!steady) begin
      while ($urandom_range(99) < 13) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= addr;
    do @(posedge clk_i); while (!s_axis_tready);
    got = lease_step(mode, addr);
    pending_leases.push_back(typed ? want : got);
    items_sent++;
  endtask

  // Stops offering and waits until every result has been taken.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_leases.size() != 0);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Read the register straight back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) report_mismatch("register read-back", prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NETWORK) pool_net = val;
    else pool_mask = val;
  endtask

  task automatic check_lease();
    lease_t want;
    if (pending_leases.size() == 0) begin
      report_mismatch("result with nothing pending", m_axis_tdata, '0);
    end else begin
      want = pending_leases.pop_front();
      if (m_axis_tuser !== want.status)
        report_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.status});
      if (m_axis_tdata !== want.grant)
        report_mismatch("granted address", m_axis_tdata, want.grant);
    end
    leases_seen++;
  endtask

  // Result side: random stalls, one long hold-off, and a stall-free stretch.
  initial begin : result_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_lease();
      if (!held && leases_seen == 500) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin : request_side
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] span;
    logic [31:0] base;
    logic [31:0] addr;
    logic        mode;
    int unsigned pick;
    int unsigned prefix;
    int unsigned burst;
    int unsigned alloc_pct;
    fail_count  = 0;
    items_sent  = 0;
    leases_seen = 0;
    cycle_count = 0;
    steady      = 1'b0;
    pool_net    = NET_RESET;
    pool_mask   = MASK_RESET;
    foreach (lease_map[i]) lease_map[i] = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_ALLOC;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_REQ) begin
        offer(PLAN[k].mode, PLAN[k].value, PLAN[k].typed, PLAN[k].want);
      end else begin
        settle();
        cfg_write(PLAN[k].kind == ROW_NET ? REG_NETWORK : REG_MASK, PLAN[k].value);
      end
    end

    // Random phases: a new subnet, then a burst of requests within it.
    while (items_sent < ITEM_TARGET) begin
      settle();
      pick = $urandom_range(99);
      if (pick < 50) prefix = $urandom_range(30, 26);
      else if (pick < 70) prefix = $urandom_range(25, 24);
      else if (pick < 80) prefix = $urandom_range(32, 31);
      else prefix = $urandom_range(23, 0);
      mask = 32'hFFFF_FFFF << (32 - prefix);
      if (pick >= 90) mask = $urandom();
      net = $urandom();
      pick = $urandom_range(99);
      if (pick < 8) begin
        cfg_write(REG_NETWORK, net);
      end else if (pick < 15) begin
        cfg_write(REG_MASK, mask);
      end else if (pick < 57) begin
        cfg_write(REG_NETWORK, net);
        cfg_write(REG_MASK, mask);
      end else begin
        cfg_write(REG_MASK, mask);
        cfg_write(REG_NETWORK, net);
      end

      span      = pool_size();
      base      = pool_base();
      burst     = $urandom_range(90, 20);
      alloc_pct = $urandom_range(75, 30);
      repeat (burst) begin
        mode = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
        pick = $urandom_range(99);
        if (mode == MODE_ALLOC) addr = $urandom();
        else if (pick < 65 && span != 0) addr = base + $urandom_range(span - 1, 0);
        else if (pick < 75) addr = $urandom_range(1) ? base - 1 : base + span;
        else if (pick < 90) addr = $urandom();
        else addr = base ^ (32'd1 << $urandom_range(31, 0));
        offer(mode, addr, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
